/* src/assert_macros.svh */
// Assertion macros shared by the button press classifier RTL.
// Needs clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define BPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the following cycle.
`define BPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/bpc_pkg.sv */
// Package for the button press classifier: event codes, register indexes,
// configuration struct and reset values. No dependencies.
package bpc_pkg;

    localparam int TIME_W    = 32;
    localparam int MS_W      = 16;
    localparam int ID_W      = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int CNT_W     = 2;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SHORT  = 2'd1,
        EV_LONG   = 2'd2,
        EV_DOUBLE = 2'd3
    } event_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE      = 3'd0,
        REG_LONG_START    = 3'd1,
        REG_LONG_DURATION = 3'd2,
        REG_BUTTON_NUMBER = 3'd3
    } cfg_reg_t;

    localparam logic [CNT_W-1:0] CNT_IDLE   = 2'd0;
    localparam logic [CNT_W-1:0] CNT_SINGLE = 2'd1;
    localparam logic [CNT_W-1:0] CNT_DOUBLE = 2'd2;
    localparam logic [CNT_W-1:0] CNT_BAD    = 2'd3;

    localparam logic [MS_W-1:0] DEBOUNCE_RST      = 16'd50;
    localparam logic [MS_W-1:0] LONG_START_RST    = 16'd500;
    localparam logic [MS_W-1:0] LONG_DURATION_RST = 16'd1500;
    localparam logic [ID_W-1:0] BUTTON_NUMBER_RST = 8'd0;

    typedef struct packed {
        logic [MS_W-1:0] debounce_ms;
        logic [MS_W-1:0] long_start_ms;
        logic [MS_W-1:0] long_duration_ms;
        logic [ID_W-1:0] button_number;
    } cfg_t;

endpackage

/* src/button_press_classifier_top.sv */
// Top level of the button press classifier: input register, core, result register.
// Depends on bpc_pkg, bpc_cfg_regs, bpc_core and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready, level, time_ms) carries one pin sample per
//   transaction; level 0 means pressed, time_ms is a wrapping millisecond stamp.
//   Output channel (out_valid/out_ready, event_res, source_id) returns exactly one
//   transaction per input: event 0 none, 1 short, 2 long, 3 double press.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   debounce, long start, long duration and button number; cfg_ready is always
//   high and unknown indexes are ignored. Write only while the block is idle.
//   Path: an accepted sample waits in the input register; the state update
//   and the result register take it in one pass once the output is free.
//   Throughput: 1 transaction per cycle while out_ready does not stall the output.
//   Reset: state and valid flags reset, channels empty; data regs are not reset.
//   Stall: a held result stays in the output register; the input register keeps
//   accepting until it is also full, then in_ready drops.
`include "assert_macros.svh"

module button_press_classifier_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             level,
    input  logic [bpc_pkg::TIME_W-1:0]       time_ms,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       event_res,
    output logic [bpc_pkg::ID_W-1:0]         source_id,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bpc_pkg::CFG_DAT_W-1:0]    cfg_data
);
    import bpc_pkg::*;

    cfg_t              cfg;
    event_t            ev;
    logic              advance;

    logic              in_valid_reg;
    logic              level_reg;
    logic [TIME_W-1:0] time_reg;
    logic              out_valid_reg;
    event_t            event_reg;
    logic [ID_W-1:0]   source_reg;

    bpc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bpc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .level   (level_reg),
        .time_ms (time_reg),
        .cfg     (cfg),
        .ev      (ev)
    );

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign event_res = event_reg;
    assign source_id = source_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            level_reg <= level;
            time_reg  <= time_ms;
        end
        if (advance)
        begin
            event_reg  <= ev;
            source_reg <= cfg.button_number;
        end
    end

    `BPC_ASSERT_NEXT(a_hold_input, in_valid_reg && !advance,
                     in_valid_reg && $stable(time_reg) && $stable(level_reg),
                     "pending sample lost before processing")
    `BPC_ASSERT_NEXT(a_result_loaded, advance, out_valid_reg,
                     "processed sample produced no result")

endmodule

/* src/bpc_cfg_regs.sv */
// Configuration register file of the button press classifier.
// Depends on bpc_pkg.
module bpc_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bpc_pkg::CFG_DAT_W-1:0]    cfg_data,
    output bpc_pkg::cfg_t                    cfg
);
    import bpc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DEBOUNCE:      cfg_next.debounce_ms      = cfg_data;
                REG_LONG_START:    cfg_next.long_start_ms    = cfg_data;
                REG_LONG_DURATION: cfg_next.long_duration_ms = cfg_data;
                REG_BUTTON_NUMBER: cfg_next.button_number    = cfg_data[ID_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms      <= DEBOUNCE_RST;
            cfg_reg.long_start_ms    <= LONG_START_RST;
            cfg_reg.long_duration_ms <= LONG_DURATION_RST;
            cfg_reg.button_number    <= BUTTON_NUMBER_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* src/bpc_core.sv */
// Debounce and press classification state with its update logic.
// Depends on bpc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bpc_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          level,
    input  logic [bpc_pkg::TIME_W-1:0]    time_ms,
    input  bpc_pkg::cfg_t                 cfg,
    output bpc_pkg::event_t               ev
);
    import bpc_pkg::*;

    logic              prev_level_reg,  prev_level_next;
    logic [TIME_W-1:0] last_change_reg, last_change_next;
    logic [TIME_W-1:0] press_start_reg, press_start_next;
    logic [CNT_W-1:0]  press_count_reg, press_count_next;
    logic              long_marked_reg, long_marked_next;

    logic [TIME_W-1:0] stable_time;
    logic [TIME_W-1:0] age;
    logic              pressed;

    always_comb
    begin
        last_change_next = (level != prev_level_reg) ? time_ms : last_change_reg;
        stable_time      = time_ms - last_change_next;
        pressed          = (stable_time > {{(TIME_W-MS_W){1'b0}}, cfg.debounce_ms}) && !level;
        age              = time_ms - press_start_reg;
        prev_level_next  = level;
        press_count_next = press_count_reg;
        press_start_next = press_start_reg;
        long_marked_next = long_marked_reg;
        ev               = EV_NONE;

        if (pressed)
        begin
            if (press_count_reg == CNT_IDLE)
            begin
                press_count_next = CNT_SINGLE;
                press_start_next = time_ms;
            end
            else if (long_marked_reg && press_count_reg == CNT_SINGLE)
            begin
                press_count_next = CNT_DOUBLE;
                press_start_next = time_ms;
            end
        end
        else if (press_count_reg != CNT_IDLE)
        begin
            priority if (press_count_reg == CNT_DOUBLE)
            begin
                press_count_next = CNT_IDLE;
                press_start_next = '0;
                long_marked_next = 1'b0;
                ev               = EV_DOUBLE;
            end
            else if (age > {{(TIME_W-MS_W){1'b0}}, cfg.long_duration_ms})
            begin
                press_count_next = CNT_IDLE;
                press_start_next = '0;
                long_marked_next = 1'b0;
                ev               = EV_LONG;
            end
            else if (age > {{(TIME_W-MS_W){1'b0}}, cfg.long_start_ms})
            begin
                long_marked_next = 1'b1;
            end
            else if (press_count_reg == CNT_SINGLE)
            begin
                press_count_next = CNT_IDLE;
                press_start_next = '0;
                long_marked_next = 1'b0;
                ev               = EV_SHORT;
            end
            else
            begin
                ev = EV_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg  <= 1'b1;
            last_change_reg <= '0;
            press_start_reg <= '0;
            press_count_reg <= CNT_IDLE;
            long_marked_reg <= 1'b0;
        end
        else if (step)
        begin
            prev_level_reg  <= prev_level_next;
            last_change_reg <= last_change_next;
            press_start_reg <= press_start_next;
            press_count_reg <= press_count_next;
            long_marked_reg <= long_marked_next;
        end
    end

    `BPC_ASSERT(a_count_legal, press_count_reg != CNT_BAD, "press count reached three")
    `BPC_ASSERT(a_mark_pending, !long_marked_reg || press_count_reg != CNT_IDLE,
                "long mark set with no press pending")
    `BPC_ASSERT_NEXT(a_double_clears, step && ev == EV_DOUBLE,
                     press_count_reg == CNT_IDLE && !long_marked_reg,
                     "double press did not clear the press")

endmodule

/* tb/tb.sv */
// Self-checking testbench for button_press_classifier_top: debounce and short, long and
// double press classification, checked against an in-line press classifier.
// Depends on bpc_pkg and the RTL under src only.
`timescale 1ns / 100ps

module tb;

    import bpc_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 6;
    localparam int MAX_REPORTS   = 20;
    localparam int SEG_ITEMS     = 130;
    localparam int SEGS_PER_MODE = 4;
    localparam int FIRST_UNUSED  = REG_BUTTON_NUMBER + 1;
    localparam int LAST_UNUSED   = 2 ** CFG_IDX_W - 1;

    typedef struct packed {
        event_t          ev;
        logic [ID_W-1:0] id;
    } press_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 level;
    logic [TIME_W-1:0]    time_ms;
    logic                 out_valid;
    logic                 out_ready;
    logic [1:0]           event_res;
    logic [ID_W-1:0]      source_id;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    // classifier state and register copies
    logic              pin_prev       = 1'b1;
    logic [TIME_W-1:0] last_edge_ms   = '0;
    logic [TIME_W-1:0] press_t0       = '0;
    logic [CNT_W-1:0]  press_cnt      = CNT_IDLE;
    logic              long_seen      = 1'b0;
    logic [MS_W-1:0]   cfg_debounce   = DEBOUNCE_RST;
    logic [MS_W-1:0]   cfg_long_start = LONG_START_RST;
    logic [MS_W-1:0]   cfg_long_dur   = LONG_DURATION_RST;
    logic [ID_W-1:0]   cfg_button     = BUTTON_NUMBER_RST;

    press_result_t     expected_results[$];
    logic [TIME_W-1:0] t_now = '0;
    int                send_idle_pct  = 14;
    int                recv_stall_pct = 73;
    int                n_sent         = 0;
    int                n_results      = 0;
    int                n_errors       = 0;
    int                n_settings     = 0;
    int                quiet_cycles   = 0;
    int                ev_seen[4]     = '{default: 0};

    button_press_classifier_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .level     (level),
        .time_ms   (time_ms),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .event_res (event_res),
        .source_id (source_id),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void clear_pending_press();
        press_cnt = CNT_IDLE;
        press_t0  = '0;
        long_seen = 1'b0;
    endfunction

    function automatic event_t classify_sample(input logic lvl, input logic [TIME_W-1:0] ts);
        logic [TIME_W-1:0] stable_for;
        logic [TIME_W-1:0] age;
        logic              pressed;
        event_t            ev;
        ev = EV_NONE;
        if (lvl != pin_prev)
            last_edge_ms = ts;
        stable_for = ts - last_edge_ms;
        pressed    = (stable_for > {16'd0, cfg_debounce}) && !lvl;
        pin_prev   = lvl;
        if (pressed)
        begin
            if (press_cnt == CNT_IDLE)
            begin
                press_cnt = CNT_SINGLE;
                press_t0  = ts;
            end
            else if (long_seen && press_cnt == CNT_SINGLE)
            begin
                press_cnt = CNT_DOUBLE;
                press_t0  = ts;
            end
        end
        else if (press_cnt != CNT_IDLE)
        begin
            age = ts - press_t0;
            if (press_cnt == CNT_DOUBLE)
            begin
                clear_pending_press();
                ev = EV_DOUBLE;
            end
            else if (age > {16'd0, cfg_long_dur})
            begin
                clear_pending_press();
                ev = EV_LONG;
            end
            else if (age > {16'd0, cfg_long_start})
                long_seen = 1'b1;
            else if (press_cnt == CNT_SINGLE)
            begin
                clear_pending_press();
                ev = EV_SHORT;
            end
        end
        return ev;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("%0t MISMATCH %s at result %0d: got %0h expected %0h",
                     $realtime, what, n_results, got, want);
    endtask

    always @(posedge clk)
    begin : predict_proc
        press_result_t r;
        if (rst_n && in_valid && in_ready)
        begin
            r.ev = classify_sample(level, time_ms);
            r.id = cfg_button;
            expected_results.push_back(r);
        end
    end

    always @(posedge clk)
    begin : check_proc
        press_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            n_results++;
            if (expected_results.size() == 0)
                report_mismatch("result with nothing expected", {event_res, source_id}, 0);
            else
            begin
                want = expected_results.pop_front();
                if (event_res !== want.ev)
                    report_mismatch("event", event_res, want.ev);
                if (source_id !== want.id)
                    report_mismatch("source id", source_id, want.id);
                ev_seen[want.ev]++;
            end
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // leave in_valid high after the transaction so back-to-back samples need no toggle
    task automatic send_sample(input logic lvl, input logic [TIME_W-1:0] ts);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99, 0) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        level    <= lvl;
        time_ms  <= ts;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        n_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_DEBOUNCE:      cfg_debounce   = data;
            REG_LONG_START:    cfg_long_start = data;
            REG_LONG_DURATION: cfg_long_dur   = data;
            REG_BUTTON_NUMBER: cfg_button     = data[ID_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic apply_config(input int unsigned deb, input int unsigned start,
                                input int unsigned dur, input int unsigned button);
        drain_results();
        write_register(REG_DEBOUNCE, CFG_DAT_W'(deb));
        write_register(REG_LONG_START, CFG_DAT_W'(start));
        write_register(REG_LONG_DURATION, CFG_DAT_W'(dur));
        write_register(REG_BUTTON_NUMBER, CFG_DAT_W'(button));
        // unmapped index: must leave every register as it is
        write_register(CFG_IDX_W'($urandom_range(LAST_UNUSED, FIRST_UNUSED)),
                       CFG_DAT_W'($urandom()));
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic press_gesture();
        int unsigned deb;
        int unsigned start;
        int unsigned dur_lim;
        int unsigned hold;
        int unsigned gap;
        int unsigned bucket;
        deb     = cfg_debounce;
        start   = cfg_long_start;
        dur_lim = cfg_long_dur;
        if ($urandom_range(9, 0) == 0)
        begin
            repeat ($urandom_range(4, 1))
            begin
                if ($urandom_range(7, 0) == 0)
                    t_now = $urandom();
                else
                    t_now += $urandom_range(2 * deb + 2, 0);
                send_sample($urandom_range(1, 0), t_now);
            end
        end
        else
        begin
            bucket = $urandom_range(2, 0);
            case (bucket)
                0:       hold = $urandom_range(start, 0);
                1:       hold = $urandom_range(dur_lim, start + 1);
                default: hold = $urandom_range(dur_lim + dur_lim / 2 + 50, dur_lim + 1);
            endcase
            if ($urandom_range(3, 0) == 0)
            begin
                send_sample(1'b0, t_now);
                t_now += $urandom_range(deb, 0);
                send_sample(1'b1, t_now);
            end
            t_now += $urandom_range(deb + 10, 1);
            send_sample(1'b0, t_now);
            t_now += deb + 1 + $urandom_range(3, 0);
            send_sample(1'b0, t_now);
            if ($urandom_range(1, 0) != 0)
                send_sample(1'b0, t_now + TIME_W'(hold / 2));
            t_now += hold;
            send_sample(1'b1, t_now);
            // second press while the first one is still waiting
            if (bucket == 1 && $urandom_range(2, 0) != 0)
            begin
                gap = (dur_lim > hold) ? dur_lim - hold : 0;
                t_now += $urandom_range(gap, 0);
                send_sample(1'b0, t_now);
                t_now += deb + 1 + $urandom_range(3, 0);
                send_sample(1'b0, t_now);
                t_now += $urandom_range(start, 0);
                send_sample(1'b1, t_now);
            end
            repeat ($urandom_range(2, 0))
            begin
                t_now += $urandom_range(dur_lim + dur_lim / 2 + 10, 0);
                send_sample(1'b1, t_now);
            end
        end
    endtask

    task automatic test_directed_presses();
        send_sample(1'b1, 32'd0);
        send_sample(1'b0, 32'd100);
        send_sample(1'b0, 32'd151);
        send_sample(1'b1, 32'd300);
        send_sample(1'b0, 32'd1000);
        send_sample(1'b0, 32'd1051);
        send_sample(1'b0, 32'd3000);
        send_sample(1'b1, 32'd3000);
        send_sample(1'b0, 32'd4000);
        send_sample(1'b0, 32'd4100);
        send_sample(1'b1, 32'd4800);
        send_sample(1'b0, 32'd4900);
        send_sample(1'b0, 32'd4960);
        send_sample(1'b1, 32'd5000);
        send_sample(1'b0, 32'd6000);
        send_sample(1'b0, 32'd6051);
        send_sample(1'b1, 32'd6700);
        send_sample(1'b1, 32'd7600);
        // wrap of the millisecond counter
        send_sample(1'b0, 32'hFFFF_FFC0);
        send_sample(1'b0, 32'h0000_0010);
        send_sample(1'b1, 32'h0000_0100);
        // press that starts exactly at time zero
        send_sample(1'b0, 32'hFFFF_FF00);
        send_sample(1'b0, 32'h0000_0000);
        send_sample(1'b1, 32'h0000_000A);
        send_sample(1'b1, 32'hFFFF_FFFF);
    endtask

    task automatic test_random_presses(input int send_pct, input int recv_pct);
        int unsigned deb;
        int unsigned start;
        int unsigned dur_lim;
        int unsigned button;
        int          seg_goal;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int k = 0; k < SEGS_PER_MODE; k++)
        begin
            case (k)
                0:
                begin
                    deb = 0; start = 0; dur_lim = 0; button = 16'hFFFF;
                end
                1:
                begin
                    deb = 16'hFFFF; start = 16'hFFFF; dur_lim = 16'hFFFF; button = 0;
                end
                2:
                begin
                    start   = $urandom_range(65535, 1000);
                    dur_lim = $urandom_range(start - 1, 0);
                    deb     = $urandom_range(200, 0);
                    button  = $urandom_range(65535, 0);
                end
                default:
                begin
                    deb     = $urandom_range(100, 0);
                    start   = $urandom_range(1000, 1);
                    dur_lim = start + $urandom_range(3000, 1);
                    button  = $urandom_range(65535, 0);
                end
            endcase
            apply_config(deb, start, dur_lim, button);
            t_now    = $urandom();
            seg_goal = n_sent + SEG_ITEMS;
            while (n_sent < seg_goal)
                press_gesture();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        level     = 1'b1;
        time_ms   = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_DEBOUNCE;
        cfg_data  = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_presses();
        test_random_presses(14, 73);
        test_random_presses(73, 14);
        test_random_presses(0, 0);
        drain_results();
        $display("Sent %0d pin samples across %0d register settings and three pacing modes.",
                 n_sent, n_settings);
        $display("Checked %0d results: %0d short, %0d long, %0d double, %0d without event.",
                 n_results, ev_seen[EV_SHORT], ev_seen[EV_LONG], ev_seen[EV_DOUBLE],
                 ev_seen[EV_NONE]);
        if (n_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
